/* hdl/vvm_pkg.sv */
// Shared types and constants of the version vector merge block.
package vvm_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int ID_W              = 64;
   localparam int SEQ_W             = 64;

   // request codes
   localparam logic REQ_REMOTE = 1'b0;
   localparam logic REQ_LOCAL  = 1'b1;

   typedef enum logic [1:0] {
      KIND_RANGE   = 2'd0,
      KIND_SUMMARY = 2'd1,
      KIND_UPDATE  = 2'd2
   } result_kind_type;

   // token walking the cell chain, one per request
   typedef struct packed {
      logic              active;
      logic              is_local;
      logic [ID_W-1:0]   key;
      logic [SEQ_W-1:0]  seq;
      logic              last_entry;
      logic              done;
      logic              has_range;
      logic [SEQ_W-1:0]  first;
      logic              local_newer;
   } token_type;

   typedef struct packed {
      result_kind_type   result_kind;
      logic [ID_W-1:0]   result_node;
      logic [SEQ_W-1:0]  first_missing;
      logic [SEQ_W-1:0]  last_missing;
      logic              local_newer;
      logic              remote_newer;
      logic              table_full;
      logic              run_end;
   } result_type;

endpackage

/* hdl/vvm_req_if.sv */
// Request channel interface: valid/ready plus one vector entry or update.
interface vvm_req_if;
   import vvm_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [ID_W-1:0]   node_id;
   logic [SEQ_W-1:0]  seq_number;
   logic              last_entry;

   modport source (output valid, req_type, node_id, seq_number, last_entry, input ready);
   modport sink   (input valid, req_type, node_id, seq_number, last_entry, output ready);
endinterface

/* hdl/vvm_rsp_if.sv */
// Response channel interface: valid/ready plus one result item.
interface vvm_rsp_if;
   import vvm_pkg::*;

   logic              valid;
   logic              ready;
   result_kind_type   result_kind;
   logic [ID_W-1:0]   result_node;
   logic [SEQ_W-1:0]  first_missing;
   logic [SEQ_W-1:0]  last_missing;
   logic              local_newer;
   logic              remote_newer;
   logic              table_full;
   logic              run_end;

   modport source (output valid, result_kind, result_node, first_missing, last_missing,
                   local_newer, remote_newer, table_full, run_end, input ready);
   modport sink   (input valid, result_kind, result_node, first_missing, last_missing,
                   local_newer, remote_newer, table_full, run_end, output ready);
endinterface

/* hdl/vvm_cell.sv */
// One table entry of the version vector, with its stage of the token chain.
module vvm_cell (
   input  logic               clock,
   input  logic               reset,
   input  vvm_pkg::token_type up_tok,
   output vvm_pkg::token_type down_tok
);
   import vvm_pkg::*;

   logic             valid_ff,   valid_in;
   logic             covered_ff, covered_in;
   logic [ID_W-1:0]  node_ff,    node_in;
   logic [SEQ_W-1:0] seq_ff,     seq_in;
   token_type        tok_ff,     tok_in;

   logic             hit;
   logic             ins;
   logic [SEQ_W-1:0] seq_inc;

   assign hit     = up_tok.active && !up_tok.done && valid_ff && (node_ff == up_tok.key);
   assign ins     = up_tok.active && !up_tok.done && !valid_ff;
   assign seq_inc = seq_ff + SEQ_W'(1);

   always_comb begin
      valid_in   = valid_ff;
      covered_in = covered_ff;
      node_in    = node_ff;
      seq_in     = seq_ff;
      tok_in     = up_tok;

      if (hit) begin
         tok_in.done = 1'b1;
         if (up_tok.is_local == REQ_LOCAL) begin
            seq_in     = seq_inc;
            covered_in = 1'b0;
            tok_in.seq = seq_inc;
         end else if (seq_ff < up_tok.seq) begin
            seq_in           = up_tok.seq;
            covered_in       = 1'b1;
            tok_in.has_range = 1'b1;
            tok_in.first     = seq_inc;
         end else if (seq_ff == up_tok.seq) begin
            covered_in = 1'b1;
         end
      end

      // entries fill from the front, so the first empty cell means a miss
      if (ins) begin
         valid_in    = 1'b1;
         node_in     = up_tok.key;
         tok_in.done = 1'b1;
         if (up_tok.is_local == REQ_LOCAL) begin
            seq_in     = SEQ_W'(1);
            covered_in = 1'b0;
            tok_in.seq = SEQ_W'(1);
         end else begin
            seq_in           = up_tok.seq;
            covered_in       = 1'b1;
            tok_in.has_range = 1'b1;
            tok_in.first     = SEQ_W'(1);
         end
      end

      if (up_tok.active) begin
         tok_in.local_newer = up_tok.local_newer | (valid_in & ~covered_in);
         if (up_tok.last_entry) begin
            covered_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         covered_ff    <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         covered_ff <= covered_in;
         tok_ff     <= tok_in;
      end
      node_ff <= node_in;
      seq_ff  <= seq_in;
   end

   assign down_tok = tok_ff;

endmodule

/* hdl/vvm_rsp_queue.sv */
// Two-slot result buffer driving the response channel.
module vvm_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [1:0]          push_count,
   input  vvm_pkg::result_type push_a,
   input  vvm_pkg::result_type push_b,
   output logic                empty,
   vvm_rsp_if.source           rsp_chan
);
   import vvm_pkg::*;

   logic [1:0] count_ff;
   result_type slot0_ff;
   result_type slot1_ff;
   logic       pop;

   assign pop   = (count_ff != 2'd0) && rsp_chan.ready;
   assign empty = (count_ff == 2'd0);

   // push is only issued while empty, so it never meets a pop
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (push) begin
         count_ff <= push_count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
      if (push) begin
         slot0_ff <= push_a;
         slot1_ff <= push_b;
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_chan.valid         = (count_ff != 2'd0);
   assign rsp_chan.result_kind   = slot0_ff.result_kind;
   assign rsp_chan.result_node   = slot0_ff.result_node;
   assign rsp_chan.first_missing = slot0_ff.first_missing;
   assign rsp_chan.last_missing  = slot0_ff.last_missing;
   assign rsp_chan.local_newer   = slot0_ff.local_newer;
   assign rsp_chan.remote_newer  = slot0_ff.remote_newer;
   assign rsp_chan.table_full    = slot0_ff.table_full;
   assign rsp_chan.run_end       = slot0_ff.run_end;

endmodule

/* hdl/version_vector_merge.sv */
// Top level of the version vector merge block.
//
// Usage notes:
//  - req_chan takes one remote vector entry (req_type remote, last_entry on the
//    final one) or a local update (req_type local) per transfer.
//  - rsp_chan returns up to two results per request: a missing range for a
//    newer remote entry, then a summary after the final entry; a local update
//    returns one update result. run_end marks the last result of a request.
//  - csr_write_enable/csr_write_data set own_node_id; write only while idle.
//  - Each request walks a chain of TABLE_ENTRIES cells, one cell per cycle.
//    A new request is taken only once the last one's results are in the buffer.
//  - A request that causes no result frees the block as its token leaves the
//    chain, or later if the buffer still holds results.
//  - Reset clears the table, covered marks, the summary flag and own_node_id.
//  - When rsp_chan stalls, results wait in a two-slot buffer; the chain takes
//    one more request and holds its finished token until the buffer drains.
module version_vector_merge #(
   parameter int TABLE_ENTRIES = vvm_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   vvm_req_if.sink                  req_chan,
   vvm_rsp_if.source                rsp_chan,
   input  logic                     csr_write_enable,
   input  logic [vvm_pkg::ID_W-1:0] csr_write_data
);
   import vvm_pkg::*;

   logic [ID_W-1:0] own_id_ff;
   logic            busy_ff;       // a request is in the chain or finishing
   logic            remote_seen_ff; // some entry of this vector was newer
   token_type       tok0_ff;       // token entering the first cell
   token_type       fin_ff;        // token leaving the last cell
   logic            fin_valid_ff;
   token_type       chain [TABLE_ENTRIES+1];

   logic       accept;
   logic       push;
   logic       q_empty;
   logic       has_range;
   logic [1:0] push_count;
   result_type res_range;
   result_type res_summary;
   result_type res_update;
   result_type push_a;

   assign req_chan.ready = !busy_ff;
   assign accept         = req_chan.valid && !busy_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff <= '0;
      end else if (csr_write_enable) begin
         own_id_ff <= csr_write_data;
      end
   end

   // load a fresh token; local updates search for own_node_id
   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff.active <= 1'b0;
      end else begin
         tok0_ff.active <= accept;
      end
      if (accept) begin
         tok0_ff.is_local    <= req_chan.req_type;
         tok0_ff.key         <= (req_chan.req_type == REQ_LOCAL) ? own_id_ff
                                                                 : req_chan.node_id;
         tok0_ff.seq         <= req_chan.seq_number;
         tok0_ff.last_entry  <= req_chan.last_entry && (req_chan.req_type == REQ_REMOTE);
         tok0_ff.done        <= 1'b0;
         tok0_ff.has_range   <= 1'b0;
         tok0_ff.first       <= '0;
         tok0_ff.local_newer <= 1'b0;
      end
   end

   assign chain[0] = tok0_ff;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      vvm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_tok   (chain[i]),
         .down_tok (chain[i+1])
      );
   end

   // catch the token as it leaves the chain (single pulse per request)
   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (chain[TABLE_ENTRIES].active) begin
         fin_valid_ff <= 1'b1;
      end else if (push) begin
         fin_valid_ff <= 1'b0;
      end
      if (chain[TABLE_ENTRIES].active) begin
         fin_ff <= chain[TABLE_ENTRIES];
      end
   end

   // a token that never found or claimed a cell means the table was full
   assign has_range = fin_ff.has_range || !fin_ff.done;

   always_comb begin
      res_range.result_kind   = KIND_RANGE;
      res_range.result_node   = fin_ff.key;
      res_range.first_missing = fin_ff.done ? fin_ff.first : SEQ_W'(1);
      res_range.last_missing  = fin_ff.seq;
      res_range.local_newer   = 1'b0;
      res_range.remote_newer  = 1'b0;
      res_range.table_full    = !fin_ff.done;
      res_range.run_end       = !fin_ff.last_entry;

      res_summary.result_kind   = KIND_SUMMARY;
      res_summary.result_node   = '0;
      res_summary.first_missing = '0;
      res_summary.last_missing  = '0;
      res_summary.local_newer   = fin_ff.local_newer;
      res_summary.remote_newer  = remote_seen_ff | has_range;
      res_summary.table_full    = 1'b0;
      res_summary.run_end       = 1'b1;

      res_update.result_kind   = KIND_UPDATE;
      res_update.result_node   = fin_ff.key;
      res_update.first_missing = '0;
      res_update.last_missing  = fin_ff.done ? fin_ff.seq : '0;
      res_update.local_newer   = 1'b0;
      res_update.remote_newer  = 1'b0;
      res_update.table_full    = !fin_ff.done;
      res_update.run_end       = 1'b1;

      if (fin_ff.is_local == REQ_LOCAL) begin
         push_a     = res_update;
         push_count = 2'd1;
      end else begin
         push_a     = has_range ? res_range : res_summary;
         push_count = {1'b0, has_range} + {1'b0, fin_ff.last_entry};
      end
   end

   assign push = fin_valid_ff && q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         remote_seen_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (push) begin
            busy_ff <= 1'b0;
         end
         if (push && (fin_ff.is_local == REQ_REMOTE)) begin
            if (fin_ff.last_entry) begin
               remote_seen_ff <= 1'b0;
            end else if (has_range) begin
               remote_seen_ff <= 1'b1;
            end
         end
      end
   end

   vvm_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_count (push_count),
      .push_a     (push_a),
      .push_b     (res_summary),
      .empty      (q_empty),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench for version_vector_merge: directed and random vector merges checked against a table mirror.
module tb_top;
   import vvm_pkg::*;

   localparam int N_ENTRIES = TABLE_ENTRIES_DEF;
   // node ids shared by the directed and random parts; 0 and all-ones are the extremes
   localparam int POOL_SIZE = 12;
   // long enough for a request to walk the chain, with the output buffer on top
   localparam int DRAIN_CYCLES = 3 * (N_ENTRIES + 3);
   localparam int PRINT_CAP = 40;
   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [ID_W-1:0] csr_write_data;

   vvm_req_if req ();
   vvm_rsp_if rsp ();

   version_vector_merge u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req),
      .rsp_chan         (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // Mirror of the version vector table.
   // Node and sequence slots are only read where the valid bit is set.
   // ------------------------------------------------------------------
   bit               tbl_valid   [N_ENTRIES];
   bit [ID_W-1:0]    tbl_node    [N_ENTRIES];
   bit [SEQ_W-1:0]   tbl_seq     [N_ENTRIES];
   bit               tbl_covered [N_ENTRIES];
   bit               remote_ahead;          // some entry of the open vector gave a range
   bit [ID_W-1:0]    own_id;                // mirror of the own node register

   result_type       pending_results[$];    // results still owed by the block, oldest first
   logic [ID_W-1:0]  node_pool[POOL_SIZE];

   int send_idle_pct;                       // chance in 100 that the sender idles a cycle
   int rsp_stall_pct;                       // chance in 100 that the receiver stalls a cycle
   int items_sent;
   int results_seen;
   int mismatch_count;
   int range_count;
   int summary_count;
   int update_count;
   int full_count;

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int lookup_node(logic [ID_W-1:0] id);
      for (int i = 0; i < N_ENTRIES; i++)
         if (tbl_valid[i] && tbl_node[i] == id)
            return i;
      return -1;
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < N_ENTRIES; i++)
         if (!tbl_valid[i])
            return i;
      return -1;
   endfunction

   function automatic void queue_result(result_kind_type kind, logic [ID_W-1:0] node,
                                        logic [SEQ_W-1:0] first, logic [SEQ_W-1:0] last,
                                        logic lnew, logic rnew, logic full, logic fin);
      result_type r;
      r.result_kind   = kind;
      r.result_node   = node;
      r.first_missing = first;
      r.last_missing  = last;
      r.local_newer   = lnew;
      r.remote_newer  = rnew;
      r.table_full    = full;
      r.run_end       = fin;
      pending_results = {pending_results, r};
   endfunction

   // Applies one accepted transfer to the mirror and queues the results it owes.
   function automatic void predict_merge(logic rtype, logic [ID_W-1:0] id,
                                         logic [SEQ_W-1:0] seq, logic last);
      int   idx;
      int   slot;
      logic lnew;
      if (rtype == REQ_LOCAL) begin
         idx = lookup_node(own_id);
         if (idx >= 0) begin
            // bump own sequence; wraps from all-ones to zero
            tbl_seq[idx]     = tbl_seq[idx] + 64'd1;
            tbl_covered[idx] = 1'b0;
            queue_result(KIND_UPDATE, own_id, '0, tbl_seq[idx], 1'b0, 1'b0, 1'b0, 1'b1);
         end else begin
            slot = free_slot();
            if (slot < 0) begin
               queue_result(KIND_UPDATE, own_id, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1);
            end else begin
               tbl_valid[slot]   = 1'b1;
               tbl_node[slot]    = own_id;
               tbl_seq[slot]     = 64'd1;
               tbl_covered[slot] = 1'b0;
               queue_result(KIND_UPDATE, own_id, '0, 64'd1, 1'b0, 1'b0, 1'b0, 1'b1);
            end
         end
      end else begin
         idx = lookup_node(id);
         if (idx < 0) begin
            // absent node is always newer, even at sequence zero (empty range 1..0)
            slot = free_slot();
            if (slot >= 0) begin
               tbl_valid[slot]   = 1'b1;
               tbl_node[slot]    = id;
               tbl_seq[slot]     = seq;
               tbl_covered[slot] = 1'b1;
            end
            remote_ahead = 1'b1;
            queue_result(KIND_RANGE, id, 64'd1, seq, 1'b0, 1'b0, slot < 0, !last);
         end else if (tbl_seq[idx] < seq) begin
            queue_result(KIND_RANGE, id, tbl_seq[idx] + 64'd1, seq, 1'b0, 1'b0, 1'b0, !last);
            tbl_seq[idx]     = seq;
            tbl_covered[idx] = 1'b1;
            remote_ahead     = 1'b1;
         end else if (tbl_seq[idx] == seq) begin
            tbl_covered[idx] = 1'b1;
         end
         // a higher local entry stays uncovered and shows up as local newer
         if (last) begin
            lnew = 1'b0;
            for (int i = 0; i < N_ENTRIES; i++) begin
               if (tbl_valid[i] && !tbl_covered[i])
                  lnew = 1'b1;
               tbl_covered[i] = 1'b0;
            end
            queue_result(KIND_SUMMARY, '0, '0, '0, lnew, remote_ahead, 1'b0, 1'b1);
            remote_ahead = 1'b0;
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side. Fields change at the falling edge; the transfer is
   // taken at the rising edge where valid and ready are both high.
   // valid stays high after a transfer until the next falling edge, where
   // either the next item or an idle gap replaces it.
   // ------------------------------------------------------------------
   task automatic send_item(logic rtype, logic [ID_W-1:0] id, logic [SEQ_W-1:0] seq,
                            logic last);
      int gap;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         @(negedge clock);
         req.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req.valid      <= 1'b1;
      req.req_type   <= rtype;
      req.node_id    <= id;
      req.seq_number <= seq;
      req.last_entry <= last;
      do @(posedge clock); while (req.ready !== 1'b1);
      predict_merge(rtype, id, seq, last);
      items_sent++;
   endtask

   // node, sequence and last mark are don't-care on a local update; scramble them
   task automatic send_local_update();
      send_item(REQ_LOCAL, rand_word(), rand_word(), 1'($urandom_range(1)));
   endtask

   // Drops valid, waits for every owed result, then lets any result-free
   // request finish its walk through the chain.
   task automatic settle_block();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_own_id(logic [ID_W-1:0] value);
      settle_block();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      own_id = value;
   endtask

   // Picks a sequence close to what the table holds, so ranges, equal and
   // lower entries all come up; whole-word values now and then.
   function automatic logic [SEQ_W-1:0] pick_seq(logic [ID_W-1:0] id);
      int               idx;
      int               roll;
      logic [SEQ_W-1:0] base;
      idx  = lookup_node(id);
      roll = $urandom_range(255);
      if (idx < 0) begin
         if (roll < 64)
            return '0;
         else if (roll < 128)
            return rand_word();
         else
            return 64'($urandom_range(1, 40));
      end
      base = tbl_seq[idx];
      if (roll < 96)
         return base + 64'($urandom_range(1, 5));
      else if (roll < 160)
         return base;
      else if (roll < 208)
         return (base > 64'd5) ? base - 64'($urandom_range(1, 5)) : base;
      else if (roll < 224)
         return rand_word();
      else if (roll < 240)
         return '0;
      else
         return base + 64'($urandom);
   endfunction

   // One well-formed remote vector over pool nodes, last mark on its final entry,
   // with the odd local update slipped in between entries.
   task automatic send_random_vector();
      int              len;
      logic [ID_W-1:0] id;
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(9) == 0)
            send_local_update();
         id = node_pool[$urandom_range(POOL_SIZE - 1)];
         send_item(REQ_REMOTE, id, pick_seq(id), k == len - 1);
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: receiver stalls are redrawn every falling edge; each
   // transfer is compared field by field with the oldest owed result.
   // ------------------------------------------------------------------
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            if (mismatch_count < PRINT_CAP)
               $display("%0t ns: unexpected result, expected none actual kind %0d node %h",
                        $time, rsp.result_kind, rsp.result_node);
            mismatch_count++;
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            check_field("result_kind", 64'(want.result_kind), 64'(rsp.result_kind));
            check_field("result_node", want.result_node, rsp.result_node);
            check_field("first_missing", want.first_missing, rsp.first_missing);
            check_field("last_missing", want.last_missing, rsp.last_missing);
            check_field("local_newer", 64'(want.local_newer), 64'(rsp.local_newer));
            check_field("remote_newer", 64'(want.remote_newer), 64'(rsp.remote_newer));
            check_field("table_full", 64'(want.table_full), 64'(rsp.table_full));
            check_field("run_end", 64'(want.run_end), 64'(rsp.run_end));
            case (want.result_kind)
               KIND_RANGE:   range_count++;
               KIND_SUMMARY: summary_count++;
               default:      update_count++;
            endcase
            if (want.table_full)
               full_count++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Own entry absent, so the first update inserts sequence 1, the next bumps it.
   task automatic test_local_update();
      write_own_id(node_pool[0]);
      send_local_update();
      send_local_update();
   endtask

   // Absent node at sequence zero, higher, equal and lower entries, a local
   // update inside a vector, and one node repeated within a vector.
   task automatic test_remote_merge();
      send_item(REQ_REMOTE, node_pool[1], '0, 1'b0);
      send_item(REQ_REMOTE, node_pool[0], 64'd5, 1'b0);
      send_item(REQ_REMOTE, node_pool[2], SEQ_MAX, 1'b0);
      send_local_update();                                  // uncovers own entry
      send_item(REQ_REMOTE, node_pool[0], 64'd6, 1'b0);     // equal, covers it again
      send_item(REQ_REMOTE, node_pool[3], 64'd10, 1'b1);    // range then summary
      send_item(REQ_REMOTE, node_pool[0], 64'd3, 1'b1);     // lower: summary only
      send_item(REQ_REMOTE, node_pool[3], 64'd12, 1'b0);
      send_item(REQ_REMOTE, node_pool[3], 64'd15, 1'b0);
      send_item(REQ_REMOTE, node_pool[3], 64'd15, 1'b1);
   endtask

   // Own id all-ones: drive its sequence to the top, then let updates wrap it.
   task automatic test_own_wrap();
      write_own_id(node_pool[1]);
      send_item(REQ_REMOTE, node_pool[1], SEQ_MAX, 1'b1);
      send_local_update();
      send_local_update();
      send_item(REQ_REMOTE, node_pool[1], '0, 1'b1);
   endtask

   // Random vectors in four pacing phases, own id changed between phases.
   task automatic test_random_phases();
      int idle_by_phase  [4] = '{0, 86, 0, 22};
      int stall_by_phase [4] = '{0, 0, 86, 22};
      int own_pick       [4];
      int target;
      own_pick = '{1, $urandom_range(2, POOL_SIZE - 1), 0, $urandom_range(2, POOL_SIZE - 1)};
      for (int p = 0; p < 4; p++) begin
         write_own_id(node_pool[own_pick[p]]);
         send_idle_pct = idle_by_phase[p];
         rsp_stall_pct = stall_by_phase[p];
         target = items_sent + 370;
         while (items_sent < target) begin
            case ($urandom_range(19))
               0, 1:    send_local_update();
               2:       send_item(REQ_REMOTE, node_pool[$urandom_range(POOL_SIZE - 1)],
                                  rand_word(), 1'($urandom_range(1)));
               default: send_random_vector();
            endcase
         end
      end
   endtask

   // Runs last: entries never free, so once full the table stays full.
   task automatic test_table_full();
      logic [ID_W-1:0] id;
      send_idle_pct = 22;
      rsp_stall_pct = 22;
      write_own_id(rand_word());                          // own entry absent
      while (free_slot() >= 0)
         send_item(REQ_REMOTE, rand_word(), pick_seq('0), $urandom_range(3) == 0);
      send_item(REQ_REMOTE, rand_word(), '0, 1'b0);       // insert dropped
      send_local_update();                                // own insert dropped
      send_item(REQ_REMOTE, rand_word(), rand_word(), 1'b1);
      repeat (30) begin
         if ($urandom_range(4) == 0) begin
            send_local_update();
         end else begin
            id = ($urandom_range(1) == 0) ? rand_word()
                                          : node_pool[$urandom_range(POOL_SIZE - 1)];
            send_item(REQ_REMOTE, id, pick_seq(id), $urandom_range(2) == 0);
         end
      end
   endtask

   task automatic finish_run();
      settle_block();
      $display("Sent %0d requests, checked %0d results: %0d ranges, %0d summaries, %0d updates",
               items_sent, results_seen, range_count, summary_count, update_count);
      $display("%0d results flagged a full table; pacing ran free, sender-idle, stalled, mixed",
               full_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   endtask

   initial begin
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.req_type     = REQ_REMOTE;
      req.node_id      = '0;
      req.seq_number   = '0;
      req.last_entry   = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      items_sent       = 0;
      results_seen     = 0;
      mismatch_count   = 0;
      range_count      = 0;
      summary_count    = 0;
      update_count     = 0;
      full_count       = 0;
      remote_ahead     = 1'b0;
      own_id           = '0;
      for (int i = 0; i < N_ENTRIES; i++) begin
         tbl_valid[i]   = 1'b0;
         tbl_covered[i] = 1'b0;
      end
      node_pool[0] = '0;
      node_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         node_pool[i] = rand_word();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_local_update();
      test_remote_merge();
      test_own_wrap();
      test_random_phases();
      test_table_full();
      finish_run();
   end

   // Watchdog: far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("Timeout with %0d results still owed", pending_results.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
